FILE: rtl/core/bsc_pkg.sv
package bsc_pkg;

  localparam logic [1:0] CMD_LOAD_KNOT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_POINT = 2'd1;
  localparam logic [1:0] CMD_EVALUATE   = 2'd2;
  localparam logic [1:0] CMD_SPARE      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic REG_DEGREE      = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  // divider operand widths: |basis| << 16 plus half the divisor, and |den|
  localparam int NUM_W = 61;
  localparam int DEN_W = 19;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         table_index;
    logic [16:0]        knot_value;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [16:0]        param_u;
  } in_t;

  typedef struct packed {
    logic signed [23:0] curve_x;
    logic signed [23:0] curve_y;
    logic [6:0]         span_found;
    logic [1:0]         status;
  } out_t;

endpackage

FILE: rtl/core/bsc_div.sv
module bsc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsc_pkg::NUM_W-1:0]   num,
  input  logic [bsc_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [bsc_pkg::NUM_W-1:0]   quo
);

  logic [bsc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [bsc_pkg::NUM_W-1:0] work_r, work_nxt;
  logic [bsc_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [bsc_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [bsc_pkg::DEN_W:0]   trial;
  logic [bsc_pkg::DEN_W:0]   diff;
  logic                      ge;

  // restoring division, one quotient bit a cycle; quotient shifts into work_r
  assign trial = {rem_r, work_r[bsc_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      work_nxt = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = bsc_pkg::CNT_W'(bsc_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = {work_r[bsc_pkg::NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[bsc_pkg::DEN_W-1:0] : trial[bsc_pkg::DEN_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == bsc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign quo  = work_r;

endmodule

FILE: rtl/core/bspline_curve_point.sv
// B-spline curve point evaluator. Load items write one knot or one control
// point and return a result in the cycle after the transfer; an evaluate item
// runs a bounded binary span search, the Cox-de Boor recurrence and a
// multiply-accumulate over the degree+1 control points on one sequencer with
// a restoring divider and a two-pass 24x23 multiplier. The span search takes
// no steps when u is the end knot, else at most about log2(point_count - p)
// + 1; evaluation time is set almost wholly by the divider, which runs once
// per basis term; a term with a zero denominator skips the divider. Badly
// configured requests are answered from the idle state, out-of-range ones
// once the first and last knots are checked. Knot and point tables have no
// reset and must be loaded before use.
module bspline_curve_point #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DEGREE = 7,
  parameter int KNOT_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bsc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bsc_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [6:0]     cfg_data
);

  localparam int KW = $clog2(KNOT_DEPTH);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int JW = $clog2(MAX_DEGREE + 2);

  localparam logic [4:0] S_IDLE = 5'd0,  S_CW   = 5'd1,  S_C0   = 5'd2,  S_CM   = 5'd3;
  localparam logic [4:0] S_CE   = 5'd4,  S_SA   = 5'd5,  S_SB   = 5'd6,  S_SC   = 5'd7;
  localparam logic [4:0] S_BI   = 5'd8,  S_BJA  = 5'd9,  S_BJB  = 5'd10, S_BJC  = 5'd11;
  localparam logic [4:0] S_BJD  = 5'd12, S_RDEN = 5'd13, S_RDIV = 5'd14, S_RT   = 5'd15;
  localparam logic [4:0] S_RM1  = 5'd16, S_RM2  = 5'd17, S_MA   = 5'd18, S_MB   = 5'd19;
  localparam logic [4:0] S_MC   = 5'd20, S_MXD  = 5'd21, S_MYD  = 5'd22, S_FIN  = 5'd23;
  localparam logic [4:0] S_MLO  = 5'd24, S_MHI  = 5'd25;

  localparam logic signed [63:0] BASIS_LIM = 64'sd17592186044416; // 2^44
  localparam logic signed [63:0] MAC_LIM   = 64'sd17179869184;    // 2^34

  logic [16:0]        knot_mem [KNOT_DEPTH];
  logic signed [23:0] px_mem   [MAX_POINTS];
  logic signed [23:0] py_mem   [MAX_POINTS];

  logic [4:0]          state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]          degree_r;
  logic [6:0]          pcount_r;
  logic [16:0]         u_r, u_nxt;
  logic [KW-1:0]       kaddr_r, kaddr_nxt, span_r, span_nxt;
  logic [KW-1:0]       low_r, low_nxt, high_r, high_nxt, mid_r, mid_nxt;
  logic [16:0]         kq_r, km_r, km_nxt;
  logic [PW-1:0]       paddr_r, paddr_nxt;
  logic signed [23:0]  pxq_r, pyq_r;
  logic [JW-1:0]       j_r, j_nxt, r_r, r_nxt;
  logic signed [45:0]  basis_r [MAX_DEGREE+1];
  logic signed [45:0]  basis_nxt [MAX_DEGREE+1];
  logic signed [17:0]  left_r [MAX_DEGREE+1];
  logic signed [17:0]  left_nxt [MAX_DEGREE+1];
  logic signed [17:0]  right_r [MAX_DEGREE+1];
  logic signed [17:0]  right_nxt [MAX_DEGREE+1];
  logic signed [45:0]  saved_r, saved_nxt, t_r, t_nxt;
  logic                neg_r, neg_nxt, mneg_r, mneg_nxt;
  logic [23:0]         ma_r, ma_nxt;
  logic [45:0]         mb_r, mb_nxt;
  logic [69:0]         macc_r, macc_nxt;
  logic signed [61:0]  accx_r, accx_nxt, accy_r, accy_nxt;
  bsc_pkg::out_t       out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                accept, out_free, cfg_bad;
  logic [KW-1:0]       p_k, pc_k;
  logic [IW-1:0]       r_idx, r1_idx, jr_idx, j_idx;
  logic signed [18:0]  den_s;
  logic [18:0]         den_mag;
  logic [45:0]         bmag, tmag;
  logic                div_start, div_done;
  logic [bsc_pkg::NUM_W-1:0] div_num, div_quo;
  logic [63:0]         rnd_mag;
  logic signed [63:0]  mres, mfull;
  logic signed [63:0]  wide_a, wide_b;
  logic [60:0]         qsat;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [45:0] mag46(input logic signed [45:0] v);
    return v[45] ? 46'(-v) : 46'(v);
  endfunction

  function automatic logic [23:0] mag24(input logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

  function automatic logic signed [23:0] fin24(input logic signed [61:0] acc);
    logic [61:0]        m;
    logic [31:0]        q;
    logic signed [63:0] v;
    m = acc[61] ? 62'(-acc) : 62'(acc);
    q = 32'((m + 62'd536870912) >> 30);
    v = acc[61] ? -$signed({32'd0, q}) : $signed({32'd0, q});
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  bsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign cfg_bad = (degree_r == 3'd0) || (32'(degree_r) > MAX_DEGREE) ||
                   (pcount_r < 7'd2) || (pcount_r <= 7'(degree_r)) ||
                   (32'(pcount_r) > MAX_POINTS) ||
                   (32'(pcount_r) + 32'(degree_r) >= KNOT_DEPTH);
  assign p_k  = KW'(degree_r);
  assign pc_k = KW'(pcount_r);

  assign r_idx  = r_r[IW-1:0];
  assign j_idx  = j_r[IW-1:0];
  assign r1_idx = IW'(r_r + 1'b1);
  assign jr_idx = IW'(j_r - r_r);

  assign den_s   = 19'(right_r[r1_idx]) + 19'(left_r[jr_idx]);
  assign den_mag = den_s[18] ? 19'(-den_s) : 19'(den_s);
  assign bmag    = mag46(basis_r[r_idx]);
  assign tmag    = mag46(t_r);
  assign div_num = (61'(bmag) << 16) + 61'(den_mag >> 1);
  assign qsat    = (div_quo > 61'(BASIS_LIM)) ? 61'(BASIS_LIM) : div_quo;

  // signed product, rounded Q.30 * Q.16 >> 16, and the exact one for the sum
  assign rnd_mag = 64'((macc_r + 70'd32768) >> 16);
  assign mres    = mneg_r ? -$signed(rnd_mag) : $signed(rnd_mag);
  assign mfull   = mneg_r ? -$signed(macc_r[63:0]) : $signed(macc_r[63:0]);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    u_nxt         = u_r;
    kaddr_nxt     = kaddr_r;
    span_nxt      = span_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    km_nxt        = km_r;
    paddr_nxt     = paddr_r;
    j_nxt         = j_r;
    r_nxt         = r_r;
    basis_nxt     = basis_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    saved_nxt     = saved_r;
    t_nxt         = t_r;
    neg_nxt       = neg_r;
    mneg_nxt      = mneg_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    macc_nxt      = macc_r;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    wide_a        = '0;
    wide_b        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          case (in_data.cmd)
            bsc_pkg::CMD_LOAD_KNOT: begin
              if (32'(in_data.table_index) >= KNOT_DEPTH) out_nxt.status = bsc_pkg::ST_BAD_INDEX;
            end
            bsc_pkg::CMD_LOAD_POINT: begin
              if (32'(in_data.table_index) >= MAX_POINTS) out_nxt.status = bsc_pkg::ST_BAD_INDEX;
            end
            bsc_pkg::CMD_EVALUATE: begin
              if (cfg_bad) begin
                out_nxt.status = bsc_pkg::ST_BAD_INDEX;
              end else begin
                out_valid_nxt = 1'b0;
                u_nxt         = in_data.param_u;
                kaddr_nxt     = '0;
                state_nxt     = S_CW;
              end
            end
            default: ;
          endcase
        end
      end
      S_CW: begin
        kaddr_nxt = pc_k + p_k;
        state_nxt = S_C0;
      end
      S_C0: begin
        kaddr_nxt = pc_k;
        if (u_r < kq_r) begin
          out_nxt        = '0;
          out_nxt.status = bsc_pkg::ST_RANGE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CM;
        end
      end
      S_CM: begin
        if (u_r > kq_r) begin
          out_nxt        = '0;
          out_nxt.status = bsc_pkg::ST_RANGE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CE;
        end
      end
      S_CE: begin
        // end knot takes the last span
        if (u_r == kq_r) begin
          span_nxt  = pc_k - 1'b1;
          state_nxt = S_BI;
        end else begin
          low_nxt   = p_k;
          high_nxt  = pc_k;
          mid_nxt   = KW'(({1'b0, p_k} + {1'b0, pc_k}) >> 1);
          kaddr_nxt = KW'(({1'b0, p_k} + {1'b0, pc_k}) >> 1);
          state_nxt = S_SA;
        end
      end
      S_SA: begin
        kaddr_nxt = mid_r + 1'b1;
        state_nxt = S_SB;
      end
      S_SB: begin
        km_nxt    = kq_r;
        state_nxt = S_SC;
      end
      S_SC: begin
        if (u_r >= km_r && u_r < kq_r) begin
          span_nxt  = mid_r;
          state_nxt = S_BI;
        end else begin
          if (u_r < km_r) high_nxt = mid_r;
          else low_nxt = mid_r;
          mid_nxt = KW'(({1'b0, (u_r < km_r) ? low_r : mid_r} +
                         {1'b0, (u_r < km_r) ? mid_r : high_r}) >> 1);
          // stop once the interval can no longer shrink
          if (mid_nxt == low_nxt) begin
            span_nxt  = mid_nxt;
            state_nxt = S_BI;
          end else begin
            kaddr_nxt = mid_nxt;
            state_nxt = S_SA;
          end
        end
      end
      S_BI: begin
        basis_nxt[0] = 46'sd1073741824;
        j_nxt        = JW'(1);
        state_nxt    = S_BJA;
      end
      S_BJA: begin
        kaddr_nxt = span_r + 1'b1 - KW'(j_r);
        state_nxt = S_BJB;
      end
      S_BJB: begin
        kaddr_nxt = span_r + KW'(j_r);
        state_nxt = S_BJC;
      end
      S_BJC: begin
        left_nxt[j_idx] = $signed({1'b0, u_r}) - $signed({1'b0, kq_r});
        state_nxt       = S_BJD;
      end
      S_BJD: begin
        right_nxt[j_idx] = $signed({1'b0, kq_r}) - $signed({1'b0, u_r});
        r_nxt            = '0;
        saved_nxt        = '0;
        state_nxt        = S_RDEN;
      end
      S_RDEN: begin
        neg_nxt = basis_r[r_idx][45] ^ den_s[18];
        if (den_s == 19'sd0) begin
          t_nxt     = '0;
          state_nxt = S_RT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          t_nxt     = neg_r ? -$signed({1'b0, qsat[44:0]}) : $signed({1'b0, qsat[44:0]});
          state_nxt = S_RT;
        end
      end
      S_RT: begin
        ma_nxt    = 24'(mag24(24'(right_r[r1_idx])));
        mb_nxt    = tmag;
        mneg_nxt  = right_r[r1_idx][17] ^ t_r[45];
        ret_nxt   = S_RM1;
        state_nxt = S_MLO;
      end
      S_RM1: begin
        wide_a           = saved_r;
        basis_nxt[r_idx] = 46'(sat64(wide_a + mres, BASIS_LIM));
        ma_nxt           = mag24(24'(left_r[jr_idx]));
        mb_nxt           = tmag;
        mneg_nxt         = left_r[jr_idx][17] ^ t_r[45];
        ret_nxt          = S_RM2;
        state_nxt        = S_MLO;
      end
      S_RM2: begin
        saved_nxt = 46'(sat64(mres, BASIS_LIM));
        r_nxt     = r_r + 1'b1;
        if (r_nxt == j_r) begin
          basis_nxt[j_idx] = saved_nxt;
          if (j_r == JW'(degree_r)) begin
            r_nxt     = '0;
            accx_nxt  = '0;
            accy_nxt  = '0;
            state_nxt = S_MA;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_BJA;
          end
        end else begin
          state_nxt = S_RDEN;
        end
      end
      S_MA: begin
        paddr_nxt = PW'(span_r - p_k + KW'(r_r));
        state_nxt = S_MB;
      end
      S_MB: begin
        state_nxt = S_MC;
      end
      S_MC: begin
        wide_b    = basis_r[r_idx];
        t_nxt     = 46'(sat64(wide_b, MAC_LIM));
        ma_nxt    = mag24(pxq_r);
        mb_nxt    = mag46(46'(sat64(wide_b, MAC_LIM)));
        mneg_nxt  = wide_b[63] ^ pxq_r[23];
        ret_nxt   = S_MXD;
        state_nxt = S_MLO;
      end
      S_MXD: begin
        accx_nxt  = 62'(64'(accx_r) + mfull);
        ma_nxt    = mag24(pyq_r);
        mb_nxt    = tmag;
        mneg_nxt  = t_r[45] ^ pyq_r[23];
        ret_nxt   = S_MYD;
        state_nxt = S_MLO;
      end
      S_MYD: begin
        accy_nxt = 62'(64'(accy_r) + mfull);
        if (r_r == JW'(degree_r)) begin
          state_nxt = S_FIN;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = S_MA;
        end
      end
      S_FIN: begin
        out_nxt.curve_x    = fin24(accx_r);
        out_nxt.curve_y    = fin24(accy_r);
        out_nxt.span_found = 7'(span_r);
        out_nxt.status     = bsc_pkg::ST_OK;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_MLO: begin
        macc_nxt  = 70'(ma_r * mb_r[22:0]);
        state_nxt = S_MHI;
      end
      S_MHI: begin
        macc_nxt  = macc_r + (70'(ma_r * mb_r[45:23]) << 23);
        state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == bsc_pkg::CMD_LOAD_KNOT &&
        32'(in_data.table_index) < KNOT_DEPTH) begin
      knot_mem[KW'(in_data.table_index)] <= in_data.knot_value;
    end
    if (accept && in_data.cmd == bsc_pkg::CMD_LOAD_POINT &&
        32'(in_data.table_index) < MAX_POINTS) begin
      px_mem[PW'(in_data.table_index)] <= in_data.point_x;
      py_mem[PW'(in_data.table_index)] <= in_data.point_y;
    end
    kq_r  <= knot_mem[kaddr_r];
    pxq_r <= px_mem[paddr_r];
    pyq_r <= py_mem[paddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      degree_r    <= 3'd3;
      pcount_r    <= 7'd4;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bsc_pkg::REG_DEGREE:      degree_r <= cfg_data[2:0];
          bsc_pkg::REG_POINT_COUNT: pcount_r <= cfg_data;
          default: ;
        endcase
      end
    end
    ret_r   <= ret_nxt;
    u_r     <= u_nxt;
    kaddr_r <= kaddr_nxt;
    span_r  <= span_nxt;
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    mid_r   <= mid_nxt;
    km_r    <= km_nxt;
    paddr_r <= paddr_nxt;
    j_r     <= j_nxt;
    r_r     <= r_nxt;
    basis_r <= basis_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    saved_r <= saved_nxt;
    t_r     <= t_nxt;
    neg_r   <= neg_nxt;
    mneg_r  <= mneg_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    macc_r  <= macc_nxt;
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: verif/tb_bspline_curve_point.sv
`timescale 1ns / 100ps

module tb_bspline_curve_point;

  localparam int  NPTS      = 64;
  localparam int  NKNOTS    = 128;
  localparam int  MAXDEG    = 7;
  localparam int  ITEM_GOAL = 1450;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam longint BASIS_SAT = longint'(1) << 44;
  localparam longint ACC_SAT   = longint'(1) << 34;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bsc_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  bsc_pkg::out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_data;

  bspline_curve_point dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the block's tables and registers
  logic [16:0]        knot_tab [NKNOTS];
  logic signed [23:0] ctrl_x [NPTS];
  logic signed [23:0] ctrl_y [NPTS];
  logic [2:0]         deg_r;
  logic [6:0]         pcount_r;

  bsc_pkg::out_t pending_pts[$];
  int     mismatches;
  int     items_sent;
  int     evals_sent;
  int     evals_ok;
  int     evals_range;
  int     evals_badcfg;
  int     phases_run;
  int     idle_pct;
  int     stall_pct;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint shr_rnd(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint div_rnd(longint num, longint den);
    longint an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an + ad / 2) / ad;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic [23:0] clip24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic bit shape_ok();
    return !(deg_r == 0 || deg_r > MAXDEG || pcount_r < 2 || pcount_r <= deg_r ||
             pcount_r > NPTS || int'(pcount_r) + int'(deg_r) >= NKNOTS);
  endfunction

  // applies one transfer to the shadow state and returns the result it must give
  function automatic bsc_pkg::out_t curve_point(bsc_pkg::in_t it);
    bsc_pkg::out_t r;
    longint u, saved, den, t, ax, ay, b;
    longint bas [MAXDEG+1];
    longint lft [MAXDEG+1];
    longint rgt [MAXDEG+1];
    int     p, n, m, lo, hi, mid, span;
    r = '0;
    r.status = bsc_pkg::ST_OK;
    case (it.cmd)
      bsc_pkg::CMD_LOAD_KNOT: begin
        knot_tab[it.table_index] = it.knot_value;
      end
      bsc_pkg::CMD_LOAD_POINT: begin
        if (it.table_index >= NPTS) r.status = bsc_pkg::ST_BAD_INDEX;
        else begin
          ctrl_x[it.table_index] = it.point_x;
          ctrl_y[it.table_index] = it.point_y;
        end
      end
      bsc_pkg::CMD_EVALUATE: begin
        if (!shape_ok()) begin
          r.status = bsc_pkg::ST_BAD_INDEX;
          return r;
        end
        p = deg_r;
        n = pcount_r - 1;
        m = n + p + 1;
        u = it.param_u;
        if (u < knot_tab[0] || u > knot_tab[m]) begin
          r.status = bsc_pkg::ST_RANGE;
          return r;
        end
        if (u == knot_tab[n+1]) span = n;
        else begin
          lo = p;
          hi = n + 1;
          mid = (lo + hi) / 2;
          for (int k = 0; k < NKNOTS; k++) begin
            if (u >= knot_tab[mid] && u < knot_tab[mid+1]) break;
            if (u < knot_tab[mid]) hi = mid;
            else lo = mid;
            mid = (lo + hi) / 2;
            if (mid == lo) break;
          end
          span = mid;
        end
        bas[0] = longint'(1) << 30;
        for (int j = 1; j <= p; j++) begin
          saved = 0;
          lft[j] = u - longint'(knot_tab[span+1-j]);
          rgt[j] = longint'(knot_tab[span+j]) - u;
          for (int q = 0; q < j; q++) begin
            den = rgt[q+1] + lft[j-q];
            t = 0;
            if (den != 0) t = clip(div_rnd(bas[q] * 65536, den), BASIS_SAT);
            bas[q] = clip(saved + shr_rnd(rgt[q+1] * t, 16), BASIS_SAT);
            saved = clip(shr_rnd(lft[j-q] * t, 16), BASIS_SAT);
          end
          bas[j] = saved;
        end
        ax = 0;
        ay = 0;
        for (int i = 0; i <= p; i++) begin
          b = clip(bas[i], ACC_SAT);
          ax += b * longint'(ctrl_x[span-p+i]);
          ay += b * longint'(ctrl_y[span-p+i]);
        end
        r.curve_x = clip24(shr_rnd(ax, 30));
        r.curve_y = clip24(shr_rnd(ay, 30));
        r.span_found = span[6:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(bsc_pkg::in_t it);
    bsc_pkg::out_t exp_r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_r = curve_point(it);
    pending_pts.insert(pending_pts.size(), exp_r);
    items_sent++;
    if (it.cmd == bsc_pkg::CMD_EVALUATE) begin
      evals_sent++;
      case (exp_r.status)
        bsc_pkg::ST_OK:    evals_ok++;
        bsc_pkg::ST_RANGE: evals_range++;
        default:           evals_badcfg++;
      endcase
    end
  endtask

  task automatic put_knot(int idx, int val);
    bsc_pkg::in_t it;
    it = '0;
    it.cmd = bsc_pkg::CMD_LOAD_KNOT;
    it.table_index = idx[6:0];
    it.knot_value = val[16:0];
    it.point_x = 24'($urandom);
    it.param_u = 17'($urandom);
    send_item(it);
  endtask

  task automatic put_point(int idx, logic [23:0] x, logic [23:0] y);
    bsc_pkg::in_t it;
    it = '0;
    it.cmd = bsc_pkg::CMD_LOAD_POINT;
    it.table_index = idx[6:0];
    it.point_x = x;
    it.point_y = y;
    it.knot_value = 17'($urandom);
    send_item(it);
  endtask

  task automatic eval_at(int u);
    bsc_pkg::in_t it;
    it = '0;
    it.cmd = bsc_pkg::CMD_EVALUATE;
    it.param_u = u[16:0];
    it.table_index = 7'($urandom);
    it.point_y = 24'($urandom);
    send_item(it);
  endtask

  task automatic send_spare_cmd();
    bsc_pkg::in_t it;
    it.cmd = bsc_pkg::CMD_SPARE;
    it.table_index = 7'($urandom);
    it.knot_value = 17'($urandom);
    it.point_x = 24'($urandom);
    it.point_y = 24'($urandom);
    it.param_u = 17'($urandom);
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bsc_pkg::REG_DEGREE) deg_r = val[2:0];
    else pcount_r = val[6:0];
  endtask

  task automatic set_shape(int p, int pc);
    write_reg(bsc_pkg::REG_DEGREE, p);
    write_reg(bsc_pkg::REG_POINT_COUNT, pc);
  endtask

  // kind 0: clamped sorted, 1: sorted, 2: unsorted over the full field
  task automatic load_curve(int kind);
    int m, lo, hi, v;
    int kq[$];
    m = pcount_r + deg_r;
    lo = ($urandom_range(1)) ? 0 : $urandom_range(0, 4000);
    hi = ($urandom_range(1)) ? 65536 : $urandom_range(60000, 65536);
    for (int i = 0; i <= m; i++) begin
      if (kind == 2) v = $urandom_range(0, 131071);
      else if (kind == 0 && i <= deg_r) v = lo;
      else if (kind == 0 && i >= m - deg_r) v = hi;
      else v = $urandom_range(lo, hi);
      kq.insert(kq.size(), v);
    end
    if (kind != 2) kq.sort();
    for (int i = 0; i <= m; i++) put_knot(i, kq[i]);
    for (int i = 0; i < pcount_r; i++) put_point(i, 24'($urandom), 24'($urandom));
  endtask

  task automatic eval_random();
    int m, k0, km, sel;
    m = pcount_r + deg_r;
    k0 = knot_tab[0];
    km = knot_tab[m];
    sel = $urandom_range(9);
    if (sel <= 5 && km >= k0) eval_at($urandom_range(k0, km));
    else if (sel == 6) eval_at(knot_tab[$urandom_range(0, m)]);
    else if (sel == 7) eval_at(km);
    else if (sel == 8) eval_at(k0);
    else eval_at($urandom_range(0, 131071));
  endtask

  task automatic test_loads();
    put_knot(0, 0);
    put_knot(127, 131071);
    put_knot(127, 65536);
    put_point(0, 24'h7FFFFF, 24'h800000);
    put_point(63, 24'h800000, 24'h7FFFFF);
    put_point(64, 24'h123456, 24'h654321);
    put_point(127, 24'hFFFFFF, 24'h000000);
    send_spare_cmd();
  endtask

  task automatic test_cubic_default();
    int kv [8] = '{0, 0, 0, 0, 65536, 65536, 65536, 65536};
    for (int i = 0; i < 8; i++) put_knot(i, kv[i]);
    for (int i = 0; i < 4; i++) put_point(i, 24'h7FFFFF - i, 24'h800000 + i);
    eval_at(0);
    eval_at(32768);
    eval_at(65536);       // end knot takes the last span
    eval_at(65537);
    put_knot(0, 100);
    eval_at(99);          // below the first knot
  endtask

  task automatic test_bad_shapes();
    set_shape(0, 4);
    eval_at(100);
    set_shape(3, 1);
    eval_at(100);
    set_shape(3, 3);
    eval_at(100);
    set_shape(7, 65);
    eval_at(100);
    set_shape(7, 127);
    eval_at(100);
  endtask

  task automatic test_extreme_shapes();
    set_shape(7, 8);
    load_curve(0);
    eval_at(knot_tab[0]);
    eval_at(knot_tab[15]);
    set_shape(1, 64);
    load_curve(1);
    eval_at(knot_tab[0]);
    eval_at(knot_tab[65]);
  endtask

  task automatic test_degenerate_knots();
    set_shape(2, 3);
    for (int i = 0; i <= 5; i++) put_knot(i, 4096);
    for (int i = 0; i < 3; i++) put_point(i, 24'($urandom), 24'($urandom));
    eval_at(4096);        // every denominator is zero
    load_curve(2);        // unsorted: the search stops where it cannot shrink
    for (int i = 0; i < 4; i++) eval_random();
  endtask

  task automatic test_random();
    int p, kind, evals, r;
    while (items_sent < ITEM_GOAL) begin
      phases_run++;
      // one stretch with no idling on either side
      idle_pct  = (phases_run >= 20 && phases_run < 26) ? 0 : 30;
      stall_pct = idle_pct;
      r = $urandom_range(99);
      if (r < 6) begin
        set_shape($urandom_range(0, 7), $urandom_range(0, 127));
        // only a bad shape is evaluated before its tables are loaded
        if (!shape_ok()) begin
          eval_at($urandom_range(0, 131071));
          continue;
        end
      end else if (r < 12) set_shape($urandom_range(4, 7), $urandom_range(8, 12));
      else if (r < 20) set_shape($urandom_range(1, 2), $urandom_range(20, 64));
      else begin
        p = $urandom_range(1, 3);
        set_shape(p, p + 1 + $urandom_range(0, 6));
      end
      kind = $urandom_range(99) < 70 ? 0 : ($urandom_range(1) ? 1 : 2);
      load_curve(kind);
      evals = (deg_r > 3) ? $urandom_range(2, 4) : $urandom_range(6, 16);
      for (int e = 0; e < evals; e++) begin
        r = $urandom_range(99);
        if (r < 8) put_knot($urandom_range(0, 127), $urandom_range(0, 131071));
        else if (r < 16) put_point($urandom_range(0, 127), 24'($urandom), 24'($urandom));
        else if (r < 20) send_spare_cmd();
        eval_random();
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    bsc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result %h", out_data);
        mismatches++;
      end else begin
        want = pending_pts.pop_front();
        if (out_data.curve_x !== want.curve_x) begin
          $error("curve_x expected %h got %h", want.curve_x, out_data.curve_x);
          mismatches++;
        end
        if (out_data.curve_y !== want.curve_y) begin
          $error("curve_y expected %h got %h", want.curve_y, out_data.curve_y);
          mismatches++;
        end
        if (out_data.span_found !== want.span_found) begin
          $error("span_found expected %0d got %0d", want.span_found, out_data.span_found);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_pts.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bsc_pkg::REG_DEGREE;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    evals_sent = 0;
    evals_ok = 0;
    evals_range = 0;
    evals_badcfg = 0;
    phases_run = 0;
    cycles = 0;
    idle_pct = 30;
    stall_pct = 30;
    deg_r = 3;
    pcount_r = 4;
    for (int i = 0; i < NKNOTS; i++) knot_tab[i] = '0;
    for (int i = 0; i < NPTS; i++) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_loads();
    test_cubic_default();
    test_bad_shapes();
    test_extreme_shapes();
    test_degenerate_knots();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (pending_pts.size() != 0) mismatches++;
    $display("%0d transfers in, %0d evaluations over %0d random curve phases",
             items_sent, evals_sent, phases_run);
    $display("evaluations: %0d in range, %0d outside knots, %0d bad shape",
             evals_ok, evals_range, evals_badcfg);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bsc_pkg.sv
rtl/core/bsc_div.sv
rtl/core/bspline_curve_point.sv
verif/tb_bspline_curve_point.sv
